[hdl/cra_pkg.sv]
package cra_pkg;

   localparam int unsigned WordW = 64;
   localparam int unsigned DenW = 63;
   localparam int unsigned MaxDigits = 18;
   localparam logic [WordW-1:0] S64_MIN = {1'b1, {(WordW-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4,
      OP_DEC = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_OVF    = 2'd1,
      STAT_DIV0   = 2'd2,
      STAT_DIGITS = 2'd3
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MUL_GO,
      S_MUL_WAIT,
      S_COMB,
      S_NORM,
      S_TZ,
      S_GCD,
      S_DIVN_GO,
      S_DIVN_WAIT,
      S_DIVD_GO,
      S_DIVD_WAIT,
      S_DONE
   } state_type;

   // magnitude as unsigned, minimum value maps to 2^63
   function automatic logic [WordW-1:0] mag64(input logic [WordW-1:0] v);
      mag64 = v[WordW-1] ? (~v + 1'b1) : v;
   endfunction

   // decimal scale 10^d for d up to 18
   function automatic logic [WordW-1:0] pow10(input logic [4:0] d);
      case (d)
         5'd0:  pow10 = 64'd1;
         5'd1:  pow10 = 64'd10;
         5'd2:  pow10 = 64'd100;
         5'd3:  pow10 = 64'd1000;
         5'd4:  pow10 = 64'd10000;
         5'd5:  pow10 = 64'd100000;
         5'd6:  pow10 = 64'd1000000;
         5'd7:  pow10 = 64'd10000000;
         5'd8:  pow10 = 64'd100000000;
         5'd9:  pow10 = 64'd1000000000;
         5'd10: pow10 = 64'd10000000000;
         5'd11: pow10 = 64'd100000000000;
         5'd12: pow10 = 64'd1000000000000;
         5'd13: pow10 = 64'd10000000000000;
         5'd14: pow10 = 64'd100000000000000;
         5'd15: pow10 = 64'd1000000000000000;
         5'd16: pow10 = 64'd10000000000000000;
         5'd17: pow10 = 64'd100000000000000000;
         5'd18: pow10 = 64'd1000000000000000000;
         default: pow10 = 64'd1;
      endcase
   endfunction

endpackage

[hdl/cra_mul.sv]
module cra_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic        ovf,
   output logic [63:0] prod
);
   import cra_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] mc_ff, mc_in;
   logic        neg_ff, neg_in;
   logic        spec_ff, spec_in;
   logic [64:0] sum;

   // shift-add over magnitudes, one multiplier bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mc_in   = mc_ff;
      neg_in  = neg_ff;
      spec_in = spec_ff;
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mc_ff} : 65'd0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         hi_in   = '0;
         lo_in   = mag64(b);
         mc_in   = mag64(a);
         neg_in  = a[63] ^ b[63];
         spec_in = (a == S64_MIN && b == 64'd1) || (b == S64_MIN && a == 64'd1);
      end else if (busy_ff) begin
         hi_in  = sum[64:1];
         lo_in  = {sum[0], lo_ff[63:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      mc_ff   <= mc_in;
      neg_ff  <= neg_in;
      spec_ff <= spec_in;
   end

   // any magnitude above 2^63-1 is flagged, minimum times one excepted
   assign done = done_ff;
   assign ovf  = ((hi_ff != 64'd0) || lo_ff[63]) && !spec_ff;
   assign prod = neg_ff ? (~lo_ff + 64'd1) : lo_ff;

endmodule

[hdl/cra_div.sv]
module cra_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quot
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] d_ff, d_in;
   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      trial   = {r_ff, q_ff[63]};
      diff    = trial - {1'b0, d_ff};
      ge      = trial >= {1'b0, d_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         r_in    = '0;
         q_in    = dividend;
         d_in    = divisor;
      end else if (busy_ff) begin
         r_in   = ge ? diff[63:0] : trial[63:0];
         q_in   = {q_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

[hdl/checked_rational_alu.sv]
// channel   direction  handshake            word
// req_      in         req_valid/req_ready  opcode, two rationals, digit count
// rsp_      out        rsp_valid/rsp_ready  reduced rational and status
//
// one request in flight; req_ready is high only while the sequencer is idle
// a word runs up to three 64-bit products through the serial multiplier, a
// binary gcd with the factor-of-two strip that takes one step a cycle, and
// the two reducing divides
// synchronous active-high reset clears the sequencer and the output valid
// a finished word waits in the output register; a new request is taken
// while it is still held, the next result then waits for rsp_ready
module checked_rational_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [63:0] req_a_num,
   input  logic [62:0] req_a_den,
   input  logic [63:0] req_b_num,
   input  logic [62:0] req_b_den,
   input  logic [4:0]  req_digit_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_res_num,
   output logic [62:0] rsp_res_den,
   output logic [1:0]  rsp_status
);
   import cra_pkg::*;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [63:0] an_ff, an_in;
   logic [63:0] bn_ff, bn_in;
   logic [62:0] ad_ff, ad_in;
   logic [62:0] bd_ff, bd_in;
   logic [4:0]  dc_ff, dc_in;
   logic [1:0]  mstep_ff, mstep_in;
   logic [63:0] p0_ff, p0_in;
   logic [63:0] p1_ff, p1_in;
   logic [63:0] p2_ff, p2_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [63:0] mn_ff, mn_in;
   logic [63:0] dm_ff, dm_in;
   logic [63:0] u_ff, u_in;
   logic [63:0] v_ff, v_in;
   logic [5:0]  k_ff, k_in;
   logic [63:0] g_ff, g_in;
   logic [63:0] qn_ff, qn_in;
   stat_type    stat_ff, stat_in;
   logic [63:0] resn_ff, resn_in;
   logic [62:0] resd_ff, resd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_num_ff, rsp_num_in;
   logic [62:0] rsp_den_ff, rsp_den_in;
   stat_type    rsp_stat_ff, rsp_stat_in;

   // shared units
   logic        mul_start, mul_done, mul_ovf;
   logic [63:0] mul_a, mul_b, mul_prod;
   logic        div_start, div_done;
   logic [63:0] div_dividend, div_quot;

   logic [63:0] ad64, bd64, scale;
   logic [1:0]  mlast;
   logic [64:0] comb_sum;
   logic [63:0] nn, dd;

   assign ad64  = {1'b0, ad_ff};
   assign bd64  = {1'b0, bd_ff};
   assign scale = pow10(dc_ff);

   // operand pairs for each product, in the order they are formed
   always_comb begin
      mul_a = an_ff;
      mul_b = bd64;
      mlast = 2'd0;
      case (op_ff)
         OP_ADD, OP_SUB: begin
            mlast = 2'd2;
            case (mstep_ff)
               2'd0:    begin mul_a = an_ff; mul_b = bd64;  end
               2'd1:    begin mul_a = bn_ff; mul_b = ad64;  end
               default: begin mul_a = ad64;  mul_b = bd64;  end
            endcase
         end
         OP_MUL: begin
            mlast = 2'd1;
            if (mstep_ff == 2'd0) begin
               mul_a = an_ff;
               mul_b = bn_ff;
            end else begin
               mul_a = ad64;
               mul_b = bd64;
            end
         end
         OP_DIV: begin
            mlast = 2'd1;
            if (mstep_ff == 2'd0) begin
               mul_a = an_ff;
               mul_b = bd64;
            end else begin
               mul_a = ad64;
               mul_b = bn_ff;
            end
         end
         OP_DEC: begin
            mlast = 2'd0;
            mul_a = an_ff;
            mul_b = scale;
         end
         default: begin
            mlast = 2'd0;
         end
      endcase
   end

   assign mul_start = (state_ff == S_MUL_GO);
   assign div_start = (state_ff == S_DIVN_GO) || (state_ff == S_DIVD_GO);
   assign div_dividend = ((state_ff == S_DIVN_GO) || (state_ff == S_DIVN_WAIT)) ? mn_ff : dm_ff;

   cra_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .ovf   (mul_ovf),
      .prod  (mul_prod)
   );

   cra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      an_in        = an_ff;
      bn_in        = bn_ff;
      ad_in        = ad_ff;
      bd_in        = bd_ff;
      dc_in        = dc_ff;
      mstep_in     = mstep_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      mn_in        = mn_ff;
      dm_in        = dm_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      qn_in        = qn_ff;
      stat_in      = stat_ff;
      resn_in      = resn_ff;
      resd_in      = resd_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      comb_sum     = '0;
      nn           = n_ff;
      dd           = d_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_type;
               an_in    = req_a_num;
               ad_in    = req_a_den;
               bn_in    = req_b_num;
               bd_in    = req_b_den;
               dc_in    = req_digit_count;
               mstep_in = '0;
               state_in = S_CHECK;
            end
         end

         // early outs: zero denominators, zero divisor, negate, digit range, reserved opcodes
         S_CHECK: begin
            stat_in  = STAT_OK;
            resn_in  = '0;
            resd_in  = '0;
            state_in = S_DONE;
            if (op_ff <= OP_DIV && (ad_ff == '0 || bd_ff == '0)) begin
               stat_in = STAT_DIV0;
            end else if (op_ff == OP_NEG && ad_ff == '0) begin
               stat_in = STAT_DIV0;
            end else if (op_ff == OP_DIV && bn_ff == '0) begin
               stat_in = STAT_DIV0;
            end else if (op_ff == OP_NEG) begin
               if (an_ff == S64_MIN) begin
                  stat_in = STAT_OVF;
               end else begin
                  n_in     = ~an_ff + 64'd1;
                  d_in     = ad64;
                  state_in = S_NORM;
               end
            end else if (op_ff == OP_DEC) begin
               if (dc_ff > 5'(MaxDigits)) begin
                  stat_in = STAT_DIGITS;
               end else begin
                  state_in = S_MUL_GO;
               end
            end else if (op_ff <= OP_DIV) begin
               state_in = S_MUL_GO;
            end else begin
               stat_in = STAT_OVF;
            end
         end

         S_MUL_GO: begin
            state_in = S_MUL_WAIT;
         end

         S_MUL_WAIT: begin
            if (mul_done) begin
               if (mul_ovf) begin
                  stat_in  = STAT_OVF;
                  state_in = S_DONE;
               end else begin
                  case (mstep_ff)
                     2'd0:    p0_in = mul_prod;
                     2'd1:    p1_in = mul_prod;
                     default: p2_in = mul_prod;
                  endcase
                  if (mstep_ff == mlast) begin
                     state_in = S_COMB;
                  end else begin
                     mstep_in = mstep_ff + 2'd1;
                     state_in = S_MUL_GO;
                  end
               end
            end
         end

         // form numerator and denominator, checking the sum or difference
         S_COMB: begin
            state_in = S_NORM;
            case (op_ff)
               OP_ADD: begin
                  comb_sum = {p0_ff[63], p0_ff} + {p1_ff[63], p1_ff};
                  n_in     = comb_sum[63:0];
                  d_in     = p2_ff;
               end
               OP_SUB: begin
                  comb_sum = {p0_ff[63], p0_ff} - {p1_ff[63], p1_ff};
                  n_in     = comb_sum[63:0];
                  d_in     = p2_ff;
               end
               OP_DEC: begin
                  comb_sum = {p0_ff[63], p0_ff} + {bn_ff[63], bn_ff};
                  n_in     = comb_sum[63:0];
                  d_in     = scale;
               end
               default: begin
                  n_in = p0_ff;
                  d_in = p1_ff;
               end
            endcase
            if (comb_sum[64] != comb_sum[63]) begin
               stat_in  = STAT_OVF;
               state_in = S_DONE;
            end
         end

         // move the sign to the numerator, then reduce
         S_NORM: begin
            if (d_ff[63]) begin
               nn = ~n_ff + 64'd1;
               dd = ~d_ff + 64'd1;
            end
            if (d_ff[63] && (n_ff == S64_MIN || d_ff == S64_MIN)) begin
               stat_in  = STAT_OVF;
               state_in = S_DONE;
            end else if (nn == '0) begin
               resn_in  = '0;
               resd_in  = 63'd1;
               state_in = S_DONE;
            end else begin
               neg_in   = nn[63];
               mn_in    = mag64(nn);
               dm_in    = dd;
               u_in     = mag64(nn);
               v_in     = dd;
               k_in     = '0;
               state_in = S_TZ;
            end
         end

         // strip common factors of two
         S_TZ: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 6'd1;
            end else begin
               state_in = S_GCD;
            end
         end

         // binary gcd, one shift or subtract a cycle
         S_GCD: begin
            if (u_ff == '0 || v_ff == '0) begin
               g_in     = (u_ff | v_ff) << k_ff;
               state_in = S_DIVN_GO;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end

         S_DIVN_GO: begin
            state_in = S_DIVN_WAIT;
         end

         S_DIVN_WAIT: begin
            if (div_done) begin
               qn_in    = div_quot;
               state_in = S_DIVD_GO;
            end
         end

         S_DIVD_GO: begin
            state_in = S_DIVD_WAIT;
         end

         S_DIVD_WAIT: begin
            if (div_done) begin
               resn_in  = neg_ff ? (~qn_ff + 64'd1) : qn_ff;
               resd_in  = div_quot[62:0];
               state_in = S_DONE;
            end
         end

         // hand the word to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_num_in   = (stat_ff == STAT_OK) ? resn_ff : '0;
               rsp_den_in   = (stat_ff == STAT_OK) ? resd_ff : '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      an_ff       <= an_in;
      bn_ff       <= bn_in;
      ad_ff       <= ad_in;
      bd_ff       <= bd_in;
      dc_ff       <= dc_in;
      mstep_ff    <= mstep_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      n_ff        <= n_in;
      d_ff        <= d_in;
      neg_ff      <= neg_in;
      mn_ff       <= mn_in;
      dm_ff       <= dm_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      k_ff        <= k_in;
      g_ff        <= g_in;
      qn_ff       <= qn_in;
      stat_ff     <= stat_in;
      resn_ff     <= resn_in;
      resd_ff     <= resd_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_status  = rsp_stat_ff;

   // a failed word carries a zero pair
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff != STAT_OK |-> rsp_num_ff == '0 && rsp_den_ff == '0)
      else $error("failed word with nonzero payload");

   // a good word has a positive denominator, and zero reads as 0/1
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff == STAT_OK |-> rsp_den_ff != '0 &&
      (rsp_num_ff != '0 || rsp_den_ff == 63'd1))
      else $error("bad denominator on good word");

   // shared units finish only while the sequencer waits on them
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_MUL_WAIT)
      else $error("multiplier done outside wait");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVN_WAIT || state_ff == S_DIVD_WAIT)
      else $error("divider done outside wait");

   // gcd is never zero when the divides start
   a_gcd_nz: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIVN_GO |-> g_ff != '0)
      else $error("zero gcd");

endmodule

[dv/checked_rational_alu_tb.sv]
`timescale 1ns / 100ps

module checked_rational_alu_tb;
   import cra_pkg::*;

   typedef struct {
      logic [2:0]  kind;
      logic [63:0] a_num;
      logic [62:0] a_den;
      logic [63:0] b_num;
      logic [62:0] b_den;
      logic [4:0]  digits;
   } calc_req_type;

   typedef struct {
      logic [63:0] num;
      logic [62:0] den;
      logic [1:0]  stat;
   } calc_rsp_type;

   localparam logic [63:0] MAX_S = 64'h7fff_ffff_ffff_ffff;
   localparam logic [62:0] MAX_D = 63'h7fff_ffff_ffff_ffff;
   localparam int unsigned NUM_RANDOM = 1830;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [63:0] req_a_num;
   logic [62:0] req_a_den;
   logic [63:0] req_b_num;
   logic [62:0] req_b_den;
   logic [4:0]  req_digit_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_res_num;
   logic [62:0] rsp_res_den;
   logic [1:0]  rsp_status;

   calc_req_type pending_words[$];
   calc_rsp_type expected_results[$];
   int unsigned error_count = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned status_seen[4] = '{0, 0, 0, 0};
   bit          hold_off = 0;      // long receiver stall request
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;

   checked_rational_alu u_dut (.*);

   // clock: 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------------
   // prediction: exact 128-bit intermediates stand in for the overflow checks
   // ---------------------------------------------------------------------------

   function automatic bit mul_too_big(logic signed [63:0] x, logic signed [63:0] y);
      logic signed [127:0] p;
      if (x == 0 || y == 0) return 1'b0;
      if (x == S64_MIN || y == S64_MIN)
         return ((x == S64_MIN) ? y : x) != 64'sd1;
      p = 128'(x) * 128'(y);
      // conservative: magnitude must fit 2^63-1, so -2^63 is flagged too
      return p > 128'sh7fff_ffff_ffff_ffff || p < -128'sh7fff_ffff_ffff_ffff;
   endfunction

   function automatic bit sum_too_big(logic signed [127:0] s);
      return s > 128'sh7fff_ffff_ffff_ffff || s < -128'sh8000_0000_0000_0000;
   endfunction

   function automatic calc_rsp_type reduce_fraction(logic signed [63:0] n,
                                                    logic signed [63:0] d);
      calc_rsp_type r;
      logic [63:0] x, y, t, mn;
      r = '{num: '0, den: '0, stat: STAT_OVF};
      if (d < 0) begin
         // sign cannot move off a minimum value
         if (n == S64_MIN || d == S64_MIN) return r;
         n = -n;
         d = -d;
      end
      r.stat = STAT_OK;
      if (n == 0) begin
         r.num = '0;
         r.den = 63'd1;
         return r;
      end
      mn = n[63] ? (~n + 64'd1) : n;
      x = mn;
      y = d;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      r.num = n[63] ? (64'd0 - mn / x) : mn / x;
      r.den = 63'(64'(d) / x);
      return r;
   endfunction

   function automatic calc_rsp_type predict_rational(calc_req_type w);
      logic signed [63:0] an, bn, ad, bd, n, d, scale, l, r;
      logic signed [127:0] s;
      logic [1:0] st;
      calc_rsp_type res;
      an = w.a_num;
      bn = w.b_num;
      ad = {1'b0, w.a_den};
      bd = {1'b0, w.b_den};
      st = STAT_OK;
      n = 0;
      d = 1;
      if (w.kind <= OP_DIV && (ad == 0 || bd == 0)) st = STAT_DIV0;
      else if (w.kind == OP_NEG && ad == 0) st = STAT_DIV0;
      else case (w.kind)
         OP_ADD, OP_SUB: begin
            if (mul_too_big(an, bd) || mul_too_big(bn, ad)) st = STAT_OVF;
            else begin
               l = an * bd;
               r = bn * ad;
               s = (w.kind == OP_ADD) ? 128'(l) + 128'(r) : 128'(l) - 128'(r);
               if (sum_too_big(s) || mul_too_big(ad, bd)) st = STAT_OVF;
               else begin
                  n = s[63:0];
                  d = ad * bd;
               end
            end
         end
         OP_MUL: begin
            if (mul_too_big(an, bn) || mul_too_big(ad, bd)) st = STAT_OVF;
            else begin
               n = an * bn;
               d = ad * bd;
            end
         end
         OP_DIV: begin
            if (bn == 0) st = STAT_DIV0;
            else if (mul_too_big(an, bd) || mul_too_big(ad, bn)) st = STAT_OVF;
            else begin
               n = an * bd;
               d = ad * bn;
            end
         end
         OP_NEG: begin
            if (an == S64_MIN) st = STAT_OVF;
            else begin
               n = -an;
               d = ad;
            end
         end
         OP_DEC: begin
            if (w.digits > MaxDigits) st = STAT_DIGITS;
            else begin
               scale = 1;
               for (int i = 0; i < w.digits; i++) scale = scale * 10;
               if (mul_too_big(an, scale)) st = STAT_OVF;
               else begin
                  s = 128'(an * scale) + 128'(bn);
                  if (sum_too_big(s)) st = STAT_OVF;
                  else begin
                     n = s[63:0];
                     d = scale;
                  end
               end
            end
         end
         default: st = STAT_OVF;   // reserved opcodes
      endcase
      if (st == STAT_OK) res = reduce_fraction(n, d);
      else res = '{num: '0, den: '0, stat: st};
      if (res.stat != STAT_OK) begin
         res.num = '0;
         res.den = '0;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // numerators: mostly small, sometimes edges or wide values
   function automatic logic [63:0] pick_num();
      case ($urandom_range(9))
         0: return S64_MIN;
         1: return MAX_S;
         2: return rand64();
         3: return rand64() >> $urandom_range(63);
         4: return 64'(-$signed(64'($urandom_range(1000))));
         5: return 64'($signed($urandom) >>> $urandom_range(31));
         default: return 64'($urandom_range(2000)) - 64'd1000;
      endcase
   endfunction

   // denominators: mostly small positive, rare zero, some wide
   function automatic logic [62:0] pick_den();
      case ($urandom_range(19))
         0: return '0;
         1: return MAX_D;
         2, 3: return 63'(rand64());
         4: return 63'(rand64() >> $urandom_range(62));
         default: return 63'($urandom_range(1000, 1));
      endcase
   endfunction

   task automatic add_word(logic [2:0] k, logic [63:0] an, logic [62:0] ad,
                           logic [63:0] bn, logic [62:0] bd, logic [4:0] dc);
      pending_words.push_back('{kind: k, a_num: an, a_den: ad, b_num: bn,
                                b_den: bd, digits: dc});
   endtask

   task automatic add_random_word();
      logic [2:0] k;
      k = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      add_word(k, pick_num(), pick_den(), pick_num(), pick_den(),
               5'($urandom_range(31)));
   endtask

   // ---------------------------------------------------------------------------
   // request driver: pops the pending queue, random gaps between words
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         // current word (if any) is taken this edge
         if (req_valid) begin
            expected_results.push_back(predict_rational(pending_words.pop_front()));
            words_sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            calc_req_type w;
            // the word on the port stays at the head until it is taken
            w = pending_words[0];
            req_valid       <= 1'b1;
            req_type        <= w.kind;
            req_a_num       <= w.a_num;
            req_a_den       <= w.a_den;
            req_b_num       <= w.b_num;
            req_b_den       <= w.b_den;
            req_digit_count <= w.digits;
            case ($urandom_range(19))
               0:       send_gap = $urandom_range(300, 40);
               1, 2, 3: send_gap = $urandom_range(4, 1);
               default: send_gap = 0;
            endcase
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result monitor and receiver stalls
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch word %0d: %s got %h expected %h", words_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_res_num, '0);
            end else begin
               calc_rsp_type e;
               e = expected_results.pop_front();
               if (rsp_status !== e.stat)
                  report_mismatch("status", 64'(rsp_status), 64'(e.stat));
               if (rsp_res_num !== e.num) report_mismatch("num", rsp_res_num, e.num);
               if (rsp_res_den !== e.den)
                  report_mismatch("den", 64'(rsp_res_den), 64'(e.den));
               status_seen[e.stat]++;
            end
            words_checked++;
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            case ($urandom_range(24))
               0:       recv_gap = $urandom_range(400, 50);
               1, 2, 3: recv_gap = $urandom_range(5, 1);
               default: recv_gap = 0;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = OP_ADD;
      req_a_num       = '0;
      req_a_den       = 63'd1;
      req_b_num       = '0;
      req_b_den       = 63'd1;
      req_digit_count = '0;
      rsp_ready       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      add_word(OP_ADD, 64'd1, 63'd2, 64'd1, 63'd3, 5'd0);
      add_word(OP_SUB, 64'd1, 63'd2, 64'd1, 63'd2, 5'd0);        // zero becomes 0/1
      add_word(OP_ADD, MAX_S, 63'd1, 64'd1, 63'd1, 5'd0);        // sum overflow
      add_word(OP_SUB, S64_MIN, 63'd1, 64'd1, 63'd1, 5'd0);
      add_word(OP_ADD, 64'd1, 63'd0, 64'd1, 63'd1, 5'd0);        // zero denominator
      add_word(OP_MUL, S64_MIN, 63'd1, 64'd1, 63'd1, 5'd0);      // minimum times one
      add_word(OP_MUL, 64'h4000_0000_0000_0000, 63'd1, -64'd2, 63'd1, 5'd0); // exact minimum
      add_word(OP_MUL, MAX_S, MAX_D, MAX_S, MAX_D, 5'd0);
      add_word(OP_MUL, 64'd6, 63'd4, 64'd10, 63'd9, 5'd0);       // unreduced operands
      add_word(OP_DIV, 64'd3, 63'd4, 64'd0, 63'd5, 5'd0);        // divide by zero value
      add_word(OP_DIV, 64'd3, 63'd4, -64'd5, 63'd7, 5'd0);       // negative divisor
      add_word(OP_DIV, S64_MIN, 63'd1, -64'd1, 63'd1, 5'd0);     // sign cannot move
      add_word(OP_DIV, 64'd1, MAX_D, -64'd1, 63'd1, 5'd0);
      add_word(OP_NEG, S64_MIN, 63'd1, 64'd0, 63'd0, 5'd0);      // negate minimum
      add_word(OP_NEG, MAX_S, 63'd6, 64'd0, 63'd0, 5'd0);
      add_word(OP_NEG, 64'd5, 63'd0, 64'd0, 63'd1, 5'd0);
      add_word(OP_DEC, 64'd3, 63'd0, 64'd14159, 63'd0, 5'd5);
      add_word(OP_DEC, -64'd2, 63'd0, 64'd5, 63'd0, 5'd18);
      add_word(OP_DEC, 64'd1, 63'd0, 64'd0, 63'd0, 5'd19);       // too many digits
      add_word(OP_DEC, 64'd1, 63'd0, 64'd0, 63'd0, 5'd31);
      add_word(OP_DEC, MAX_S, 63'd0, 64'd1, 63'd0, 5'd0);
      add_word(OP_DEC, 64'd10, 63'd0, MAX_S, 63'd0, 5'd1);
      add_word(3'd6, 64'd1, 63'd1, 64'd1, 63'd1, 5'd0);          // reserved opcodes
      add_word(3'd7, rand64(), MAX_D, rand64(), MAX_D, 5'd31);

      // sender pause: let the directed part drain completely
      wait (pending_words.size() == 0 && !req_valid && expected_results.size() == 0);

      // receiver holds off while the sender keeps offering
      for (int i = 0; i < 8; i++) add_random_word();
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;

      for (int i = 0; i < NUM_RANDOM; i++) begin
         add_random_word();
         if (pending_words.size() > 16) wait (pending_words.size() < 8);
      end
      wait (pending_words.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (700) @(posedge clock);

      $display("covered %0d words, %0d results: ok %0d, overflow %0d, div-by-zero %0d, digits %0d",
               words_sent, words_checked, status_seen[0], status_seen[1],
               status_seen[2], status_seen[3]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("checked_rational_alu_tb: done, clean");
      end else begin
         $display("checked_rational_alu_tb: done, errors");
      end
      $finish;
   end

   // watchdog: ~1900 words plus worst sender and receiver gaps
   initial begin
      #100ms;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("checked_rational_alu_tb: done, errors");
      $finish;
   end

endmodule
